>>> rtl/core/hcb_pkg.sv
// Shared types and constants of the Hill cipher block core.
// Used by the top level, the controller and the datapath; depends on nothing else.
package hcb_pkg;

    localparam int KDIM            = 4;
    localparam int KEY_FIELD_BITS  = 6;
    localparam int KEY_BITS        = 24;
    localparam int ALPH_CFG_BITS   = 7;
    localparam int BSIZE_CFG_BITS  = 3;
    localparam int OUT_LETTER_BITS = 6;
    localparam int OUT_DATA_BITS   = 8;
    localparam int CFG_IDX_BITS    = 3;
    localparam int NPERM           = 24;
    localparam int RED_IDX_BITS    = 5;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_SIZE    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHABET_SIZE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECRYPT_MODE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_ROW_ZERO  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_ROW_ONE   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_ROW_TWO   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_ROW_THREE = 3'd6;

    localparam logic [BSIZE_CFG_BITS-1:0] RST_BLOCK_SIZE    = 3'd2;
    localparam logic [ALPH_CFG_BITS-1:0]  RST_ALPHABET_SIZE = 7'd30;

    // The reduction pass walks the letter slots first, then the sixteen key entries.
    localparam logic [RED_IDX_BITS-1:0] RED_KEY_BASE = 5'd4;
    localparam logic [RED_IDX_BITS-1:0] RED_LAST_IDX = 5'd19;
    localparam logic [RED_IDX_BITS-1:0] PERM_LAST    = 5'd23;

    // All permutations of four columns, column for row r in bits 2r+1..2r.
    localparam logic [7:0] PERM_TAB [0:NPERM-1] = '{
        {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0}, {2'd3, 2'd1, 2'd2, 2'd0},
        {2'd1, 2'd3, 2'd2, 2'd0}, {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
        {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1}, {2'd3, 2'd0, 2'd2, 2'd1},
        {2'd0, 2'd3, 2'd2, 2'd1}, {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
        {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2}, {2'd3, 2'd0, 2'd1, 2'd2},
        {2'd0, 2'd3, 2'd1, 2'd2}, {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
        {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3}, {2'd2, 2'd0, 2'd1, 2'd3},
        {2'd0, 2'd2, 2'd1, 2'd3}, {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
    };
    // Bit p is set when permutation p is odd.
    localparam logic [NPERM-1:0] PERM_ODD = 24'b011001_100110_011001_100110;

    typedef enum logic [3:0] {
        S_IDLE, S_RED, S_ENC, S_EOUT, S_DPERM, S_DMUL, S_DACC,
        S_DFIN, S_INV, S_DOUT, S_DEMIT, S_SEMIT
    } t_state;

    typedef enum logic [1:0] {A_ONE, A_T, A_KEY, A_DINV} t_asel;
    typedef enum logic [1:0] {B_RAW, B_MAT, B_VEC, B_ACC} t_bsel;
    typedef enum logic [1:0] {ACC_HOLD, ACC_CLR, ACC_ADD_MM, ACC_ADD_T} t_accop;
    typedef enum logic [1:0] {T_HOLD, T_MAT, T_MM} t_top;
    typedef enum logic [1:0] {O_ACC, O_T, O_ZERO} t_osel;

    typedef struct packed {
        logic                    in_take;
        logic                    mm_start;
        t_asel                   a_sel;
        t_bsel                   b_sel;
        logic [1:0]              row;
        logic [1:0]              col;
        logic                    rep_en;
        logic [1:0]              rep;
        logic [RED_IDX_BITS-1:0] red_idx;
        logic                    red_wr;
        t_accop                  acc_op;
        logic                    acc_sub;
        t_top                    t_op;
        logic                    inv_clr;
        logic                    inv_step;
        logic                    out_load;
        t_osel                   out_sel;
        logic                    out_last;
        logic                    out_sing;
    } t_cmd;

    typedef struct packed {
        logic       blk_done;
        logic [2:0] n;
        logic       decrypt;
        logic       mm_busy;
        logic       mm_done;
        logic       inv_hit;
        logic       inv_end;
        logic       out_free;
    } t_status;

endpackage

>>> rtl/core/hill_cipher_block_core.sv
// Hill cipher block core: takes one letter per transaction, and after n letters emits
// n letters, the last with tlast. All products run through one bit-serial modular
// multiplier. A letter that does not complete a block is taken without leaving the idle
// state. A completed block first reduces the letters and sixteen key entries (20
// products), then encrypts with n*n products, or decrypts by Cramer's rule: n+1
// determinants mod m over all permutations (up to 24 terms of n-1 products each), a
// search for the inverse of the determinant over the candidates up to m-1, and n final
// products.
// Depends on hcb_pkg, hcb_ctrl and hcb_dp.
module hill_cipher_block_core #(
    parameter int MAX_DIM     = 4,
    parameter int LETTER_BITS = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [((LETTER_BITS+7)/8)*8-1:0]      i_s_tdata,  // letter
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [hcb_pkg::OUT_DATA_BITS-1:0]     o_m_tdata,  // cipher_letter
    output logic                                  o_m_tlast,
    output logic                                  o_m_tuser,  // key_singular
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [hcb_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [hcb_pkg::KEY_BITS-1:0]          i_cfg_wdata
);
    hcb_pkg::t_cmd    w_cmd;
    hcb_pkg::t_status w_st;

    assign o_cfg_ready = 1'b1;

    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_st       (w_st),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    hcb_dp #(
        .MAX_DIM     (MAX_DIM),
        .LETTER_BITS (LETTER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_letter    (i_s_tdata[LETTER_BITS-1:0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

>>> rtl/core/hcb_mulmod.sv
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle, MSB first.
// Uses nothing from the package; instantiated by the datapath.
module hcb_mulmod #(
    parameter int RW = 6,
    parameter int BW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [RW:0]   i_m,
    input  logic [RW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic          o_busy,
    output logic          o_done,
    output logic [RW-1:0] o_res
);
    localparam int BIW = $clog2(BW);

    logic            r_busy;
    logic [BIW-1:0]  r_bit;
    logic [RW-1:0]   r_acc;
    logic [BW-1:0]   r_b;
    logic [RW:0]     w_dbl, w_dred, w_add, w_sum;

    // Operand a is below m, so both correction steps need one subtract at most.
    always_comb begin
        w_dbl  = {r_acc, 1'b0};
        w_dred = (w_dbl >= i_m) ? w_dbl - i_m : w_dbl;
        w_add  = w_dred + (r_b[r_bit] ? {1'b0, i_a} : '0);
        w_sum  = (w_add >= i_m) ? w_add - i_m : w_add;
    end

    assign o_res  = w_sum[RW-1:0];
    assign o_busy = r_busy;
    assign o_done = r_busy && (r_bit == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bit  <= '0;
        end else if (!r_busy && i_start) begin
            r_busy <= 1'b1;
            r_bit  <= BIW'(BW - 1);
        end else if (r_busy) begin
            r_bit <= r_bit - 1'b1;
            if (r_bit == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_acc <= '0;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= o_res;
        end
    end

endmodule

>>> rtl/core/hcb_dp.sv
// Datapath of the Hill cipher core: configuration, letter buffer, reduced matrix,
// accumulator, inverse search and output register. Uses hcb_pkg and hcb_mulmod.
module hcb_dp #(
    parameter int MAX_DIM     = 4,
    parameter int LETTER_BITS = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hcb_pkg::t_cmd                       i_cmd,
    output hcb_pkg::t_status                    o_st,
    input  logic [LETTER_BITS-1:0]              i_letter,
    input  logic                                i_cfg_valid,
    input  logic [hcb_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [hcb_pkg::KEY_BITS-1:0]        i_cfg_wdata,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [hcb_pkg::OUT_DATA_BITS-1:0]   o_m_tdata,
    output logic                                o_m_tlast,
    output logic                                o_m_tuser
);
    localparam int RW  = LETTER_BITS;
    localparam int MW  = RW + 1;
    localparam int BW  = (RW > hcb_pkg::KEY_FIELD_BITS) ? RW : hcb_pkg::KEY_FIELD_BITS;
    localparam int IW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int XW  = (MW > hcb_pkg::ALPH_CFG_BITS) ? MW : hcb_pkg::ALPH_CFG_BITS;
    localparam int OLB = hcb_pkg::OUT_LETTER_BITS;
    localparam int KD  = hcb_pkg::KDIM;

    logic [hcb_pkg::BSIZE_CFG_BITS-1:0] r_bsize;
    logic [hcb_pkg::ALPH_CFG_BITS-1:0]  r_alph;
    logic                               r_decrypt;
    logic [hcb_pkg::KEY_BITS-1:0]       r_key [KD];

    logic [RW-1:0] r_pend [MAX_DIM];
    logic [IW-1:0] r_count;
    logic [RW-1:0] r_kr [KD][KD];
    logic [RW-1:0] r_vr [KD];
    logic [RW-1:0] r_acc, r_t, r_inv_t, r_prod;
    logic          r_ov;
    logic [OLB-1:0] r_od;
    logic          r_ol, r_ou;

    logic [2:0]    w_n, w_cnt_p1;
    logic [XW-1:0] w_alph, w_mmax, w_msat;
    logic [MW-1:0] w_m;
    logic [3:0]    w_kidx;
    logic [BW-1:0] w_raw, w_b;
    logic [RW-1:0] w_mat, w_a, w_mm_res, w_x, w_oval;
    logic [MW-1:0] w_addend, w_s, w_pnext;
    logic          w_mm_busy, w_mm_done, w_out_free;
    logic [RW+OLB-1:0] w_owide;

    // Saturated block size and modulus.
    always_comb begin
        if (r_bsize < 3'd2) begin
            w_n = 3'd2;
        end else if (r_bsize > 3'(MAX_DIM)) begin
            w_n = 3'(MAX_DIM);
        end else begin
            w_n = r_bsize;
        end
        w_alph = XW'(r_alph);
        w_mmax = XW'(1) << RW;
        if (w_alph < XW'(2)) begin
            w_msat = XW'(2);
        end else if (w_alph > w_mmax) begin
            w_msat = w_mmax;
        end else begin
            w_msat = w_alph;
        end
        w_m = MW'(w_msat);
    end

    assign w_cnt_p1 = 3'(r_count) + 3'd1;

    // Raw operand for the reduction pass: a buffered letter or a key field.
    always_comb begin
        w_kidx = 4'(i_cmd.red_idx - hcb_pkg::RED_KEY_BASE);
        if (i_cmd.red_idx < hcb_pkg::RED_KEY_BASE) begin
            if (i_cmd.red_idx < 5'(MAX_DIM)) begin
                w_raw = BW'(r_pend[i_cmd.red_idx[IW-1:0]]);
            end else begin
                w_raw = '0;
            end
        end else begin
            w_raw = BW'(r_key[w_kidx[3:2]][w_kidx[1:0] * hcb_pkg::KEY_FIELD_BITS +:
                                            hcb_pkg::KEY_FIELD_BITS]);
        end
    end

    // Matrix entry, with one column swapped for the letter vector when solving by Cramer's rule.
    assign w_mat = (i_cmd.rep_en && (i_cmd.col == i_cmd.rep)) ? r_vr[i_cmd.row]
                                                               : r_kr[i_cmd.row][i_cmd.col];

    always_comb begin
        case (i_cmd.a_sel)
            hcb_pkg::A_ONE:  w_a = RW'(1);
            hcb_pkg::A_T:    w_a = r_t;
            hcb_pkg::A_KEY:  w_a = r_kr[i_cmd.row][i_cmd.col];
            hcb_pkg::A_DINV: w_a = r_inv_t;
            default:         w_a = RW'(1);
        endcase
        case (i_cmd.b_sel)
            hcb_pkg::B_RAW: w_b = w_raw;
            hcb_pkg::B_MAT: w_b = BW'(w_mat);
            hcb_pkg::B_VEC: w_b = BW'(r_vr[i_cmd.col]);
            hcb_pkg::B_ACC: w_b = BW'(r_acc);
            default:        w_b = w_raw;
        endcase
    end

    hcb_mulmod #(
        .RW (RW),
        .BW (BW)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mm_start),
        .i_m     (w_m),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_busy  (w_mm_busy),
        .o_done  (w_mm_done),
        .o_res   (w_mm_res)
    );

    // Modular add or subtract into the accumulator; subtraction adds m - x.
    always_comb begin
        w_x      = (i_cmd.acc_op == hcb_pkg::ACC_ADD_MM) ? w_mm_res : r_t;
        w_addend = i_cmd.acc_sub ? (w_m - MW'(w_x)) : MW'(w_x);
        w_s      = MW'(r_acc) + w_addend;
        if (w_s >= w_m) begin
            w_s = w_s - w_m;
        end
        w_pnext = MW'(r_prod) + MW'(r_acc);
        if (w_pnext >= w_m) begin
            w_pnext = w_pnext - w_m;
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            hcb_pkg::O_ACC:  w_oval = r_acc;
            hcb_pkg::O_T:    w_oval = r_t;
            hcb_pkg::O_ZERO: w_oval = '0;
            default:         w_oval = '0;
        endcase
        w_owide = {{OLB{1'b0}}, w_oval};
    end

    assign w_out_free = !r_ov || i_m_tready;

    always_comb begin
        o_st.blk_done = (w_cnt_p1 >= w_n);
        o_st.n        = w_n;
        o_st.decrypt  = r_decrypt;
        o_st.mm_busy  = w_mm_busy;
        o_st.mm_done  = w_mm_done;
        o_st.inv_hit  = (r_prod == RW'(1));
        o_st.inv_end  = (MW'(r_inv_t) == (w_m - MW'(1)));
        o_st.out_free = w_out_free;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = hcb_pkg::OUT_DATA_BITS'(r_od);
    assign o_m_tlast  = r_ol;
    assign o_m_tuser  = r_ou;

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsize   <= hcb_pkg::RST_BLOCK_SIZE;
            r_alph    <= hcb_pkg::RST_ALPHABET_SIZE;
            r_decrypt <= 1'b0;
            for (int i = 0; i < KD; i++) begin
                r_key[i] <= '0;
            end
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    hcb_pkg::CFG_BLOCK_SIZE:    r_bsize   <= i_cfg_wdata[2:0];
                    hcb_pkg::CFG_ALPHABET_SIZE: r_alph    <= i_cfg_wdata[6:0];
                    hcb_pkg::CFG_DECRYPT_MODE:  r_decrypt <= i_cfg_wdata[0];
                    hcb_pkg::CFG_KEY_ROW_ZERO:  r_key[0]  <= i_cfg_wdata;
                    hcb_pkg::CFG_KEY_ROW_ONE:   r_key[1]  <= i_cfg_wdata;
                    hcb_pkg::CFG_KEY_ROW_TWO:   r_key[2]  <= i_cfg_wdata;
                    hcb_pkg::CFG_KEY_ROW_THREE: r_key[3]  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.in_take) begin
                r_count <= o_st.blk_done ? '0 : IW'(w_cnt_p1);
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take) begin
            r_pend[r_count] <= i_letter;
        end
        if (i_cmd.red_wr) begin
            if (i_cmd.red_idx < hcb_pkg::RED_KEY_BASE) begin
                r_vr[i_cmd.red_idx[1:0]] <= w_mm_res;
            end else begin
                r_kr[w_kidx[3:2]][w_kidx[1:0]] <= w_mm_res;
            end
        end
        case (i_cmd.acc_op)
            hcb_pkg::ACC_CLR:    r_acc <= '0;
            hcb_pkg::ACC_ADD_MM: r_acc <= RW'(w_s);
            hcb_pkg::ACC_ADD_T:  r_acc <= RW'(w_s);
            default: ;
        endcase
        case (i_cmd.t_op)
            hcb_pkg::T_MAT: r_t <= w_mat;
            hcb_pkg::T_MM:  r_t <= w_mm_res;
            default: ;
        endcase
        // The search stops on a hit, so r_inv_t then holds the inverse of the determinant.
        if (i_cmd.inv_clr) begin
            r_inv_t <= '0;
            r_prod  <= '0;
        end else if (i_cmd.inv_step) begin
            r_inv_t <= r_inv_t + 1'b1;
            r_prod  <= RW'(w_pnext);
        end
        if (i_cmd.out_load) begin
            r_od <= w_owide[OLB-1:0];
            r_ol <= i_cmd.out_last;
            r_ou <= i_cmd.out_sing;
        end
    end

endmodule

>>> rtl/core/hcb_ctrl.sv
// Controller of the Hill cipher core: sequences reduction, products, determinants,
// inverse search and output. Uses hcb_pkg; drives hcb_dp through t_cmd.
module hcb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hcb_pkg::t_status i_st,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output hcb_pkg::t_cmd    o_cmd
);
    hcb_pkg::t_state r_state, n_state;
    logic [hcb_pkg::RED_IDX_BITS-1:0] r_idx, n_idx;
    logic [1:0] r_row, n_row, r_col, n_col, r_rep, n_rep;
    logic       r_rep_en, n_rep_en;

    logic [7:0] w_pword;
    logic [1:0] w_pcol;
    logic       w_pvalid, w_podd, w_plast;
    logic       w_last_row, w_last_col, w_last_rep;

    always_comb begin
        w_pword = hcb_pkg::PERM_TAB[r_idx];
        w_pcol  = w_pword[{r_row, 1'b0} +: 2];
        w_podd  = hcb_pkg::PERM_ODD[r_idx];
        w_plast = (r_idx == hcb_pkg::PERM_LAST);
        // Only permutations that leave rows at and beyond n in place belong to an n by n matrix.
        w_pvalid = 1'b1;
        for (int r = 0; r < hcb_pkg::KDIM; r++) begin
            if ((3'(r) >= i_st.n) && (w_pword[2*r +: 2] != 2'(r))) begin
                w_pvalid = 1'b0;
            end
        end
        w_last_row = ({1'b0, r_row} == (i_st.n - 3'd1));
        w_last_col = ({1'b0, r_col} == (i_st.n - 3'd1));
        w_last_rep = ({1'b0, r_rep} == (i_st.n - 3'd1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hcb_pkg::S_IDLE;
            r_idx    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_rep    <= '0;
            r_rep_en <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_row    <= n_row;
            r_col    <= n_col;
            r_rep    <= n_rep;
            r_rep_en <= n_rep_en;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_row         = r_row;
        n_col         = r_col;
        n_rep         = r_rep;
        n_rep_en      = r_rep_en;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.row     = r_row;
        o_cmd.col     = r_col;
        o_cmd.rep     = r_rep;
        o_cmd.rep_en  = r_rep_en;
        o_cmd.red_idx = r_idx;
        case (r_state)
            hcb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    if (i_st.blk_done) begin
                        n_idx   = '0;
                        n_state = hcb_pkg::S_RED;
                    end
                end
            end
            hcb_pkg::S_RED: begin
                o_cmd.mm_start = !i_st.mm_busy;
                o_cmd.a_sel    = hcb_pkg::A_ONE;
                o_cmd.b_sel    = hcb_pkg::B_RAW;
                if (i_st.mm_done) begin
                    o_cmd.red_wr = 1'b1;
                    if (r_idx == hcb_pkg::RED_LAST_IDX) begin
                        n_idx        = '0;
                        n_row        = '0;
                        n_col        = '0;
                        n_rep_en     = 1'b0;
                        o_cmd.acc_op = hcb_pkg::ACC_CLR;
                        n_state      = i_st.decrypt ? hcb_pkg::S_DPERM : hcb_pkg::S_ENC;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            hcb_pkg::S_ENC: begin
                o_cmd.mm_start = !i_st.mm_busy;
                o_cmd.a_sel    = hcb_pkg::A_KEY;
                o_cmd.b_sel    = hcb_pkg::B_VEC;
                if (i_st.mm_done) begin
                    o_cmd.acc_op = hcb_pkg::ACC_ADD_MM;
                    if (w_last_col) begin
                        n_state = hcb_pkg::S_EOUT;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            hcb_pkg::S_EOUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = hcb_pkg::O_ACC;
                    o_cmd.out_last = w_last_row;
                    o_cmd.acc_op   = hcb_pkg::ACC_CLR;
                    if (w_last_row) begin
                        n_state = hcb_pkg::S_IDLE;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_col   = '0;
                        n_state = hcb_pkg::S_ENC;
                    end
                end
            end
            hcb_pkg::S_DPERM: begin
                if (w_pvalid) begin
                    o_cmd.t_op = hcb_pkg::T_MAT;
                    o_cmd.row  = 2'd0;
                    o_cmd.col  = w_pword[1:0];
                    n_row      = 2'd1;
                    n_state    = hcb_pkg::S_DMUL;
                end else if (w_plast) begin
                    n_state = hcb_pkg::S_DFIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            hcb_pkg::S_DMUL: begin
                o_cmd.mm_start = !i_st.mm_busy;
                o_cmd.a_sel    = hcb_pkg::A_T;
                o_cmd.b_sel    = hcb_pkg::B_MAT;
                o_cmd.col      = w_pcol;
                if (i_st.mm_done) begin
                    o_cmd.t_op = hcb_pkg::T_MM;
                    if (w_last_row) begin
                        n_state = hcb_pkg::S_DACC;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            hcb_pkg::S_DACC: begin
                o_cmd.acc_op  = hcb_pkg::ACC_ADD_T;
                o_cmd.acc_sub = w_podd;
                if (w_plast) begin
                    n_state = hcb_pkg::S_DFIN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = hcb_pkg::S_DPERM;
                end
            end
            hcb_pkg::S_DFIN: begin
                if (r_rep_en) begin
                    n_state = hcb_pkg::S_DOUT;
                end else begin
                    o_cmd.inv_clr = 1'b1;
                    n_state       = hcb_pkg::S_INV;
                end
            end
            hcb_pkg::S_INV: begin
                if (i_st.inv_hit) begin
                    n_rep_en     = 1'b1;
                    n_rep        = '0;
                    n_idx        = '0;
                    o_cmd.acc_op = hcb_pkg::ACC_CLR;
                    n_state      = hcb_pkg::S_DPERM;
                end else if (i_st.inv_end) begin
                    n_row   = '0;
                    n_state = hcb_pkg::S_SEMIT;
                end else begin
                    o_cmd.inv_step = 1'b1;
                end
            end
            hcb_pkg::S_DOUT: begin
                o_cmd.mm_start = !i_st.mm_busy;
                o_cmd.a_sel    = hcb_pkg::A_DINV;
                o_cmd.b_sel    = hcb_pkg::B_ACC;
                if (i_st.mm_done) begin
                    o_cmd.t_op = hcb_pkg::T_MM;
                    n_state    = hcb_pkg::S_DEMIT;
                end
            end
            hcb_pkg::S_DEMIT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = hcb_pkg::O_T;
                    o_cmd.out_last = w_last_rep;
                    if (w_last_rep) begin
                        n_state = hcb_pkg::S_IDLE;
                    end else begin
                        n_rep        = r_rep + 1'b1;
                        n_idx        = '0;
                        o_cmd.acc_op = hcb_pkg::ACC_CLR;
                        n_state      = hcb_pkg::S_DPERM;
                    end
                end
            end
            hcb_pkg::S_SEMIT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = hcb_pkg::O_ZERO;
                    o_cmd.out_last = w_last_row;
                    o_cmd.out_sing = 1'b1;
                    if (w_last_row) begin
                        n_state = hcb_pkg::S_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            default: begin
                n_state = hcb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/hcb_checker.sv
// Port-level checks for the Hill cipher block core, bound to the top level.
// Uses only the top-level ports; depends on hill_cipher_block_core.
module hcb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic       o_m_tuser
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

    // A singular key yields zero letters.
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> (o_m_tdata == 8'd0))
        else $error("singular result carries a nonzero letter");

    // No new letter is taken while a letter other than the last of its block is handed out.
    a_block_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |-> !o_s_tready)
        else $error("input taken in the middle of a block");

endmodule

bind hill_cipher_block_core hcb_checker u_hcb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
